@@ rtl/core/sbdf_pkg.sv @@
// Shared types and constants for the sphere blob distance field block.
`default_nettype none
package sbdf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned WIDTH_W    = 21;
  localparam int unsigned ACC_W      = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WIDTH = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 21'd19661;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RD   = 8'b0000_0010,
    ST_SUB  = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_SQRT = 8'b0001_0000,
    ST_DIST = 8'b0010_0000,
    ST_TSQ  = 8'b0100_0000,
    ST_DIV  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/sphere_blob_distance_field.sv @@
// Top level: sphere table and iterative smooth-minimum distance sequencer.
// Load: accepted while idle, no result, busy stays low.
// Query: a start value, then per folded sphere the steps read, subtract, shared 32x32 squarer,
// one-bit-a-cycle root and select, plus square and one-bit-a-cycle divide when the blend term
// applies; result strobed on out_valid the cycle after the last step, when busy falls and the
// next item can be taken. Receiver cannot stall.
// Synchronous active-low reset clears control and restores configuration defaults; table is not cleared.
`default_nettype none
module sphere_blob_distance_field
  import sbdf_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_cmd,
  input  wire logic [7:0]            in_slot,
  input  wire logic signed [31:0]    in_pos_x,
  input  wire logic signed [31:0]    in_pos_y,
  input  wire logic signed [31:0]    in_pos_z,
  input  wire logic [30:0]           in_radius,
  output logic                       out_valid,
  output logic signed [31:0]         out_distance,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned EW = 32 * 3 + 31;

  logic [COUNT_W-1:0] count_r;
  logic [WIDTH_W-1:0] width_r;

  state_t state_r;
  logic [EW-1:0] mem [MAX_SPHERES];
  logic [EW-1:0] rd_r;

  logic signed [31:0] px_r, py_r, pz_r;
  logic [31:0] ax_r, ay_r, az_r;
  logic [30:0] rad_r;
  logic        first_r;
  logic [CW-1:0] idx_r, n_lim;
  logic [5:0]  cnt_r;
  logic [63:0] prod_r;
  logic [65:0] sum_r;
  logic [34:0] srem_r;
  logic [32:0] root_r;
  logic signed [ACC_W-1:0] acc_r, m_r;
  logic [20:0] t_r;
  logic [41:0] tt_r;
  logic [22:0] den_r;
  logic [22:0] drem_r;
  logic [20:0] q_r;
  logic        out_valid_r;
  logic signed [31:0] out_dist_sat;

  // squarer operand select
  logic [31:0] mop;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mop = ax_r;
      2'd1:    mop = ay_r;
      default: mop = az_r;
    endcase
  end

  // square root step
  logic [36:0] s_sh, s_trial;
  logic        s_ge;
  assign s_sh    = {srem_r, sum_r[65:64]};
  assign s_trial = {2'b00, root_r[32:0], 2'b01};
  assign s_ge    = (s_sh >= s_trial);

  // division step
  logic [23:0] d_sh;
  logic        d_ge;
  assign d_sh = {drem_r, tt_r[41]};
  assign d_ge = (d_sh >= {1'b0, den_r});

  // distance and blend selection
  logic signed [ACC_W-1:0] sph_dist, diff, dabs, mn;
  assign sph_dist = $signed({{(ACC_W-33){1'b0}}, root_r}) -
                    $signed({{(ACC_W-31){1'b0}}, rad_r});
  assign diff = acc_r - sph_dist;
  assign dabs = diff[ACC_W-1] ? -diff : diff;
  assign mn   = (acc_r < sph_dist) ? acc_r : sph_dist;

  logic [31:0] cx, cy, cz;
  assign cx = first_r ? 32'd0 : rd_r[EW-1 -: 32];
  assign cy = first_r ? 32'd0 : rd_r[EW-33 -: 32];
  assign cz = first_r ? 32'd0 : rd_r[EW-65 -: 32];

  function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    absdiff = d[32] ? 32'(-d) : d[31:0];
  endfunction

  assign n_lim = (32'(count_r) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(count_r);

  // table write and registered read
  always_ff @(posedge clk) begin
    if (rst_n && state_r == ST_IDLE && start && in_cmd == CMD_LOAD &&
        32'(in_slot) < MAX_SPHERES) begin
      mem[AW'(in_slot)] <= {in_pos_x, in_pos_y, in_pos_z, in_radius};
    end
    rd_r <= mem[idx_r[AW-1:0]];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      width_r <= WIDTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SPHERE_COUNT)    count_r <= cfg_data[COUNT_W-1:0];
      if (cfg_index == CFG_SMOOTHING_WIDTH) width_r <= cfg_data[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // result beat lasts the one idle cycle after a query finishes
          out_valid_r <= 1'b0;
          if (start && in_cmd == CMD_QUERY) begin
            px_r    <= in_pos_x;
            py_r    <= in_pos_y;
            pz_r    <= in_pos_z;
            first_r <= 1'b1;
            idx_r   <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_SUB;
        ST_SUB: begin
          ax_r    <= absdiff(px_r, cx);
          ay_r    <= absdiff(py_r, cy);
          az_r    <= absdiff(pz_r, cz);
          rad_r   <= rd_r[30:0];
          sum_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= mop * mop;
          if (cnt_r != 6'd0) sum_r <= sum_r + {2'b00, prod_r};
          if (cnt_r == 6'd3) begin
            cnt_r   <= '0;
            srem_r  <= '0;
            root_r  <= '0;
            state_r <= ST_SQRT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_SQRT: begin
          sum_r  <= {sum_r[63:0], 2'b00};
          srem_r <= 35'(s_ge ? s_sh - s_trial : s_sh);
          root_r <= {root_r[31:0], s_ge};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) state_r <= ST_DIST;
        end
        ST_DIST: begin
          if (first_r) begin
            acc_r   <= sph_dist;
            first_r <= 1'b0;
            if (n_lim == '0) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_RD;
            end
          end else if (width_r == '0 || dabs >= $signed({{(ACC_W-WIDTH_W){1'b0}}, width_r})) begin
            acc_r <= mn;
            idx_r <= idx_r + CW'(1);
            if (idx_r + CW'(1) == n_lim) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_RD;
            end
          end else begin
            m_r     <= mn;
            t_r     <= width_r - dabs[20:0];
            den_r   <= {2'b00, width_r} + {width_r, 2'b00};
            state_r <= ST_TSQ;
          end
        end
        ST_TSQ: begin
          tt_r    <= t_r * t_r;
          drem_r  <= '0;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          tt_r   <= {tt_r[40:0], 1'b0};
          drem_r <= d_ge ? 23'(d_sh - {1'b0, den_r}) : d_sh[22:0];
          q_r    <= {q_r[19:0], d_ge};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd41) begin
            acc_r <= m_r - $signed({{(ACC_W-22){1'b0}}, q_r, d_ge});
            idx_r <= idx_r + CW'(1);
            if (idx_r + CW'(1) == n_lim) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // saturate the finished value
  always_comb begin
    if (acc_r > $signed(ACC_W'(32'h7FFF_FFFF)))
      out_dist_sat = 32'sh7FFF_FFFF;
    else if (acc_r < -$signed(ACC_W'(64'h8000_0000)))
      out_dist_sat = 32'sh8000_0000;
    else
      out_dist_sat = acc_r[31:0];
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_sat;

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a query in flight");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> (!busy && !out_valid))
    else $error("load started a query");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (idx_r <= n_lim))
    else $error("slot walk ran past the sphere count");

endmodule
`default_nettype wire
